### design/assert_macros.svh
// Assertion helpers included by lwwp_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lwwp_pkg.sv
// ----------------------------------------------------------------------------
// lwwp_pkg
// Types, constants and codes of the load weighted worker picker.
// ----------------------------------------------------------------------------
package lwwp_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam logic [15:0] AGE_LIMIT_RST = 16'd60;
    localparam logic [8:0] LOAD_FULL = 9'd256;

    localparam logic CMD_REGISTER = 1'b0;
    localparam logic CMD_REQUEST  = 1'b1;

    typedef enum logic [2:0] {
        ST_UPDATED = 3'd0,
        ST_ADDED   = 3'd1,
        ST_FULL    = 3'd2,
        ST_PICKED  = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef struct packed {
        logic        cmd;
        logic [31:0] worker_address;
        logic [15:0] worker_port;
        logic [8:0]  worker_load;
        logic [31:0] now_seconds;
        logic [15:0] random_fraction;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] picked_address;
        logic [15:0] picked_port;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // latch item, clear counters
        logic scan;      // process entry at scan index
        logic target;    // with scan: compute pick target from total; alone: walk running sum
        logic append;    // write new worker at fill count
        logic finish;    // load result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_request;
        logic scan_last;   // scan index is at last live entry
        logic empty;
    } t_stat;

endpackage

### design/lwwp_datapath.sv
// ----------------------------------------------------------------------------
// lwwp_datapath
// Worker table, one-entry-per-cycle scan for refresh, ageing and compaction,
// weight totals and roulette selection.
// ----------------------------------------------------------------------------
module lwwp_datapath #(
    parameter int MAX_WORKERS = lwwp_pkg::MAX_WORKERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_age_limit,
    input  lwwp_pkg::t_in_item i_item,
    input  lwwp_pkg::t_cmd     i_cmd,
    output lwwp_pkg::t_stat    o_stat,
    output lwwp_pkg::t_out_item o_result
);
    import lwwp_pkg::*;

    localparam int IW = $clog2(MAX_WORKERS);
    localparam int CW = $clog2(MAX_WORKERS + 1);
    localparam int TW = 9 + CW;

    logic [31:0] r_addr [MAX_WORKERS];
    logic [15:0] r_port [MAX_WORKERS];
    logic [8:0]  r_load [MAX_WORKERS];
    logic [31:0] r_seen [MAX_WORKERS];
    logic [CW-1:0] r_count;

    t_in_item      r_item;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_kept;
    logic          r_found;
    logic          r_added;
    logic          r_picked;
    logic [TW-1:0] r_total;
    logic [TW-1:0] r_run;
    logic [TW-1:0] r_tgt;
    logic [IW-1:0] r_sel;
    t_out_item     r_res;

    logic [IW-1:0] w_i;
    logic [IW-1:0] w_k;
    logic [8:0]    w_load_sat;
    logic          w_match;
    logic [8:0]    w_ld;
    logic [31:0]   w_seen;
    logic [31:0]   w_age;
    logic          w_keep;
    logic [8:0]    w_wt;
    logic [TW-1:0] w_run_nx;
    logic [TW+15:0] w_prod;
    t_out_item     w_res;

    assign w_i = r_idx[IW-1:0];
    assign w_k = r_kept[IW-1:0];
    assign w_load_sat = (r_item.worker_load > LOAD_FULL) ? LOAD_FULL : r_item.worker_load;
    assign w_match = (r_addr[w_i] == r_item.worker_address) && (r_port[w_i] == r_item.worker_port);
    assign w_ld   = w_match ? w_load_sat : r_load[w_i];
    assign w_seen = w_match ? r_item.now_seconds : r_seen[w_i];
    assign w_age  = r_item.now_seconds - w_seen;
    assign w_keep = (w_age <= {16'd0, i_age_limit});
    assign w_wt   = LOAD_FULL - r_load[w_i];
    assign w_run_nx = r_run + TW'(w_wt);
    assign w_prod = {16'd0, r_total} * {{TW{1'b0}}, r_item.random_fraction};

    assign o_stat.is_request = (r_item.cmd == CMD_REQUEST);
    assign o_stat.scan_last  = (r_idx + CW'(1) >= r_count);
    assign o_stat.empty      = (r_count == '0);
    assign o_result = r_res;

    always_comb begin
        w_res = '0;
        if (r_item.cmd == CMD_REQUEST) begin
            if (r_count == '0) begin
                w_res.status = ST_NONE;
            end else begin
                w_res.status         = ST_PICKED;
                w_res.picked_address = r_addr[r_sel];
                w_res.picked_port    = r_port[r_sel];
            end
        end else if (r_found) begin
            w_res.status = ST_UPDATED;
        end else if (r_added) begin
            w_res.status = ST_ADDED;
        end else begin
            w_res.status = ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.scan && r_item.cmd == CMD_REGISTER && o_stat.scan_last) begin
            r_count <= r_kept + CW'(w_keep);
        end else if (i_cmd.append) begin
            if (!r_found && r_count < CW'(MAX_WORKERS)) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_item   <= i_item;
            r_idx    <= '0;
            r_kept   <= '0;
            r_found  <= 1'b0;
            r_added  <= 1'b0;
            r_picked <= 1'b0;
            r_total  <= '0;
            r_run    <= '0;
            r_sel    <= '0;
        end else if (i_cmd.scan && i_cmd.target) begin
            // latch the target and rewind between the two request passes
            r_tgt <= w_prod[TW+15:16];
            r_idx <= '0;
            r_run <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + CW'(1);
            if (r_item.cmd == CMD_REGISTER) begin
                if (w_match) begin
                    r_found <= 1'b1;
                end
                // compact kept entries towards the front
                if (w_keep) begin
                    r_addr[w_k] <= r_addr[w_i];
                    r_port[w_k] <= r_port[w_i];
                    r_load[w_k] <= w_ld;
                    r_seen[w_k] <= w_seen;
                    r_kept      <= r_kept + CW'(1);
                end
            end else begin
                r_total <= r_total + TW'(w_wt);
            end
        end else if (i_cmd.target) begin
            // second pass: walk running sum against target
            r_idx <= r_idx + CW'(1);
            r_run <= w_run_nx;
            if (!r_picked) begin
                r_sel <= w_i;
                if (r_tgt < w_run_nx) begin
                    r_picked <= 1'b1;
                end
            end
        end else if (i_cmd.append) begin
            if (!r_found && r_count < CW'(MAX_WORKERS)) begin
                r_addr[r_count[IW-1:0]] <= r_item.worker_address;
                r_port[r_count[IW-1:0]] <= r_item.worker_port;
                r_load[r_count[IW-1:0]] <= w_load_sat;
                r_seen[r_count[IW-1:0]] <= r_item.now_seconds;
                r_added <= 1'b1;
            end
        end else if (i_cmd.finish) begin
            r_res <= w_res;
        end
    end

endmodule

### design/lwwp_ctrl.sv
// ----------------------------------------------------------------------------
// lwwp_ctrl
// Sequencer for the worker picker: accept, scan passes, append, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lwwp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  lwwp_pkg::t_stat i_stat,
    output lwwp_pkg::t_cmd  o_cmd
);
    import lwwp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_TGT, S_WALK, S_APPEND, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.start = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_SCAN: o_cmd.scan = !i_stat.empty;
            S_TGT: begin
                o_cmd.scan   = 1'b1;
                o_cmd.target = 1'b1;
            end
            S_WALK:   o_cmd.target = 1'b1;
            S_APPEND: o_cmd.append = 1'b1;
            S_FIN:    o_cmd.finish = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_stat.empty || i_stat.scan_last) begin
                        if (!i_stat.is_request) r_state <= S_APPEND;
                        else if (i_stat.empty) r_state <= S_FIN;
                        else r_state <= S_TGT;
                    end
                end
                S_TGT:    r_state <= S_WALK;
                S_WALK:   if (i_stat.scan_last) r_state <= S_FIN;
                S_APPEND: r_state <= S_FIN;
                S_FIN: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMP(a_valid_in_out, i_clk, i_rst_n, r_out_valid, r_state == S_OUT, "valid outside output state")
    `ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, o_cmd.finish, r_out_valid, "result not raised after finish")
    `ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1, $countones({o_cmd.append, o_cmd.finish, o_cmd.target}) <= 1, "conflicting commands")

endmodule

### design/load_weighted_worker_picker.sv
// With N live entries, a register scans them once, then appends; a request scans
// them for the weight total, then walks them again against the target. A register
// on an empty table still passes through the scan state. One item at a time: the
// next item is accepted only after the output handshake of the last one.
// Reset empties the table and sets the age limit to 60 seconds.
// ----------------------------------------------------------------------------
// load_weighted_worker_picker
// Worker table with refresh, ageing and load-weighted random selection.
// ----------------------------------------------------------------------------
module load_weighted_worker_picker #(
    parameter int MAX_WORKERS = lwwp_pkg::MAX_WORKERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lwwp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lwwp_pkg::t_out_item o_out_data
);
    import lwwp_pkg::*;

    logic [15:0] r_age_limit;
    t_cmd        w_cmd;
    t_stat       w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age_limit <= AGE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_age_limit <= i_cfg_wdata;
        end
    end

    lwwp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    lwwp_datapath #(.MAX_WORKERS(MAX_WORKERS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_age_limit(r_age_limit),
        .i_item(i_in_data), .i_cmd(w_cmd), .o_stat(w_stat), .o_result(o_out_data)
    );

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives register and request items into the worker picker with random
// bursts and output stalls, predicts each result from a table model of its
// own and compares every field of every result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import lwwp_pkg::*;

    localparam int NW = 16;
    localparam int DRAIN = 2 * NW + 20;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    load_weighted_worker_picker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // worker table model
    logic [15:0] age_limit;
    int          live_n;
    logic [31:0] w_addr [NW];
    logic [15:0] w_port [NW];
    logic [8:0]  w_load [NW];
    logic [31:0] w_seen [NW];

    t_in_item  pending_items [$];
    t_out_item expected_results [$];
    int  errors = 0;
    int  cycles = 0;
    bit  hold_sender = 1'b0;
    bit  sending_done = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;

    function automatic void add_pending(input t_in_item p_it);
        pending_items = {pending_items, p_it};
    endfunction

    function automatic t_out_item predict_pick(input t_in_item it);
        t_out_item r;
        logic [31:0] addr;
        logic [15:0] port;
        logic [8:0]  load;
        logic [63:0] total;
        logic [63:0] tgt;
        logic [63:0] run;
        int kept;
        int sel;
        bit found;
        r = '0;
        if (it.cmd == CMD_REGISTER) begin
            addr = it.worker_address;
            port = it.worker_port;
            load = (it.worker_load > LOAD_FULL) ? LOAD_FULL : it.worker_load;
            found = 1'b0;
            for (int i = 0; i < live_n; i++) begin
                if (w_addr[i] == addr && w_port[i] == port) begin
                    w_load[i] = load;
                    w_seen[i] = it.now_seconds;
                    found = 1'b1;
                end
            end
            kept = 0;
            for (int i = 0; i < live_n; i++) begin
                if (32'(it.now_seconds - w_seen[i]) <= {16'd0, age_limit}) begin
                    w_addr[kept] = w_addr[i];
                    w_port[kept] = w_port[i];
                    w_load[kept] = w_load[i];
                    w_seen[kept] = w_seen[i];
                    kept++;
                end
            end
            live_n = kept;
            if (found) begin
                r.status = ST_UPDATED;
            end else if (live_n >= NW) begin
                r.status = ST_FULL;
            end else begin
                w_addr[live_n] = addr;
                w_port[live_n] = port;
                w_load[live_n] = load;
                w_seen[live_n] = it.now_seconds;
                live_n++;
                r.status = ST_ADDED;
            end
        end else if (live_n == 0) begin
            r.status = ST_NONE;
        end else begin
            total = 0;
            for (int i = 0; i < live_n; i++) total += 64'(LOAD_FULL - w_load[i]);
            tgt = (64'(it.random_fraction) * total) >> 16;
            sel = live_n - 1;
            run = 0;
            for (int i = 0; i < live_n; i++) begin
                run += 64'(LOAD_FULL - w_load[i]);
                if (tgt < run) begin
                    sel = i;
                    break;
                end
            end
            r.status = ST_PICKED;
            r.picked_address = w_addr[sel];
            r.picked_port = w_port[sel];
        end
        return r;
    endfunction

    // driver: bursts and gaps
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (!(i_in_valid && !o_in_ready)) begin
                if (pending_items.size() > 0 && !hold_sender && gap_left == 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_items.pop_front();
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                    end
                    burst_left = burst_left - 1;
                    if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
                        gap_left = $urandom_range(1, 40);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left = gap_left - 1;
                end
            end
        end
    end

    // monitor: accept items, predict, compare results
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_results = {expected_results, predict_pick(i_in_data)};
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, o_out_data);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (o_out_data.status !== exp_r.status)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, o_out_data.status);
                    if (o_out_data.picked_address !== exp_r.picked_address)
                        $display("%0t: address expected %h actual %h", $time,
                                 exp_r.picked_address, o_out_data.picked_address);
                    if (o_out_data.picked_port !== exp_r.picked_port)
                        $display("%0t: port expected %h actual %h", $time,
                                 exp_r.picked_port, o_out_data.picked_port);
                    if (o_out_data !== exp_r) errors++;
                end
            end
            // stall on a pattern: long free runs, then choppy stretches
            i_out_ready <= ((cycles / 300) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // small address pool so refreshes and full tables happen often
    function automatic t_in_item make_reg(input logic [31:0] now_s, input int pool);
        t_in_item it;
        it = '0;
        it.cmd = CMD_REGISTER;
        it.worker_address = (pool > 0) ? 32'($urandom_range(0, pool)) ^ 32'hC0A8_0000
                                       : $urandom;
        it.worker_port = (pool > 0) ? 16'($urandom_range(8000, 8002)) : 16'($urandom);
        it.worker_load = ($urandom_range(0, 5) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
        if ($urandom_range(0, 9) == 0) it.worker_load = LOAD_FULL;
        it.now_seconds = now_s;
        it.random_fraction = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item make_req(input logic [31:0] now_s);
        t_in_item it;
        it = '0;
        it.cmd = CMD_REQUEST;
        it.worker_address = $urandom;
        it.worker_port = 16'($urandom);
        it.worker_load = 9'($urandom);
        it.now_seconds = now_s;
        it.random_fraction = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        return it;
    endfunction

    // sample at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_age_limit(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        age_limit = v;
    endtask

    initial begin
        t_in_item it;
        logic [31:0] now_s;
        logic [15:0] limits [4];
        age_limit = AGE_LIMIT_RST;
        live_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty request, extremes, full table, all fully loaded
        add_pending(make_req(32'd0));
        for (int i = 0; i < NW + 1; i++) begin
            it = make_reg(32'd100, 0);
            it.worker_load = LOAD_FULL;
            if (i == 0) begin
                it.worker_address = 32'hFFFF_FFFF;
                it.worker_port = 16'hFFFF;
                it.worker_load = 9'h1FF;
            end
            if (i == 1) begin
                it.worker_address = 32'd0;
                it.worker_port = 16'd0;
            end
            add_pending(it);
        end
        add_pending(make_req(32'd100));
        // refresh the first worker with zero load, then time jumps back
        it = pending_items[1];
        it.worker_load = 9'd0;
        it.now_seconds = 32'd160;
        add_pending(it);
        it = make_req(32'd160);
        it.random_fraction = 16'd0;
        add_pending(it);
        add_pending(make_reg(32'd50, 0));
        add_pending(make_req(32'hFFFF_FFFF));
        wait_idle();

        limits[0] = 16'd0;
        limits[1] = 16'hFFFF;
        limits[2] = 16'd5;
        limits[3] = 16'd60;
        now_s = 32'd1000;
        for (int ph = 0; ph < 8; ph++) begin
            write_age_limit((ph < 4) ? limits[ph] : 16'($urandom_range(0, 40)));
            for (int k = 0; k < 60; k++) begin
                if ($urandom_range(0, 15) == 0)
                    now_s = ($urandom_range(0, 1) != 0) ? now_s - $urandom_range(1, 20) : $urandom;
                else
                    now_s = now_s + $urandom_range(0, 3);
                if ($urandom_range(0, 2) == 0)
                    add_pending(make_req(now_s));
                else
                    add_pending(make_reg(now_s, ($urandom_range(0, 9) == 0) ? 0 : 24));
            end
            if (ph == 3) begin
                // mid-batch, hold the sender until every result is back
                while (pending_items.size() > 40) @(negedge i_clk);
                hold_sender = 1'b1;
                while (expected_results.size() > 0 || i_in_valid) @(negedge i_clk);
                hold_sender = 1'b0;
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
